/* hw/rtl/sssd_pkg.sv */
// Shared types and constants for the seven-segment scan shift driver.
// Holds the glyph table, digit-select codes and the beat/mode codes.
// No dependencies.
package sssd_pkg;

  typedef logic [3:0]  digit_t;
  typedef logic [15:0] frame_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] MODE_TEMP = 2'd0;
  localparam logic [1:0] MODE_ADDR = 2'd1;
  localparam logic [1:0] MODE_OFF  = 2'd2;

  localparam frame_t OFF_FRAME     = 16'hFFFF;
  localparam digit_t LETTER_C_CODE = 4'hC;

  // Segment byte, A in bit 7 down to DP in bit 0. Codes 11 and 13 draw as 8 and 0.
  function automatic logic [7:0] glyph(input digit_t code);
    logic [7:0] seg;
    case (code)
      4'd0:    seg = 8'hFC;
      4'd1:    seg = 8'h60;
      4'd2:    seg = 8'hDA;
      4'd3:    seg = 8'hF2;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'hB6;
      4'd6:    seg = 8'hBE;
      4'd7:    seg = 8'hE0;
      4'd8:    seg = 8'hFE;
      4'd9:    seg = 8'hF6;
      4'd10:   seg = 8'hEE;
      4'd11:   seg = 8'hFE;
      4'd12:   seg = 8'h9C;
      4'd13:   seg = 8'hFC;
      4'd14:   seg = 8'h9E;
      default: seg = 8'h8E;
    endcase
    return seg;
  endfunction

  // Active-low digit select byte for each scan position.
  function automatic logic [7:0] digit_select(input logic [1:0] pos);
    logic [7:0] sel;
    case (pos)
      2'd0:    sel = 8'h0E;
      2'd1:    sel = 8'h0D;
      2'd2:    sel = 8'h0B;
      default: sel = 8'h07;
    endcase
    return sel;
  endfunction

endpackage

/* hw/rtl/seven_segment_scan_shift_driver_unit.sv */
// Top level of the seven-segment scan shift driver: load/tick decode,
// decimal split, frame build and the 16-bit output shifter.
// Depends on sssd_pkg.
//
// Latency: the first bit of a tick's frame is on the output the cycle after the tick beat.
// Throughput: a frame tick occupies the shifter for 16 output beats (one per cycle while the receiver is ready);
// the next beat is taken in the cycle its last bit leaves. Loads and silent ticks do not occupy the shifter.
// Reset: display off, digits zero, scan position 0, no frame in flight.
module seven_segment_scan_shift_driver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] mode, [11:2] value, [15:12] zero
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] serial_bit, [4:1] bit_position, [7:5] zero
  output logic        m_axis_tlast
);
  import sssd_pkg::*;

  // state
  logic [1:0] display_mode;
  digit_t     dig_hund;
  digit_t     dig_tens;
  digit_t     dig_ones;
  logic [1:0] scan_pos;

  // shifter
  frame_t     frame;
  logic [3:0] bit_pos;
  logic       active;

  logic       in_beat;
  logic       out_beat;
  logic       last_beat;

  assign out_beat      = m_axis_tvalid && m_axis_tready;
  assign last_beat     = out_beat && (bit_pos == 4'd0);
  assign s_axis_tready = !active || last_beat;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // decimal split of the load value
  logic [1:0]  in_mode;
  logic [9:0]  in_value;
  logic [19:0] hund_prod;
  digit_t      hund_est;
  logic [10:0] hund_scaled;
  logic [10:0] rem_est;
  logic        hund_fix;
  digit_t      hund_next;
  logic [6:0]  rem_100;
  logic [14:0] tens_prod;
  digit_t      tens_next;
  logic [7:0]  tens_scaled;
  digit_t      ones_next;

  always_comb begin
    in_mode     = s_axis_tdata[1:0];
    in_value    = s_axis_tdata[11:2];
    // 655/65536 is just under 1/100, so the estimate is exact or one low
    hund_prod   = in_value * 10'd655;
    hund_est    = hund_prod[19:16];
    hund_scaled = hund_est * 7'd100;
    rem_est     = {1'b0, in_value} - hund_scaled;
    hund_fix    = (rem_est >= 11'd100);
    hund_next   = hund_fix ? hund_est + 4'd1 : hund_est;
    rem_100     = hund_fix ? 7'(rem_est - 11'd100) : rem_est[6:0];
    tens_prod   = rem_100 * 8'd205;
    tens_next   = tens_prod[14:11];
    tens_scaled = tens_next * 4'd10;
    ones_next   = 4'(8'(rem_100) - tens_scaled);
  end

  // frame for the current scan position
  logic   emit;
  digit_t code;
  logic   point;
  frame_t frame_next;

  always_comb begin
    emit  = 1'b0;
    code  = dig_ones;
    point = 1'b0;
    unique case (display_mode)
      MODE_TEMP: begin
        emit = 1'b1;
        case (scan_pos)
          2'd0: begin
            code  = dig_hund;
            point = 1'b1;
          end
          2'd1:    code = dig_tens;
          2'd2:    code = dig_ones;
          default: code = LETTER_C_CODE;
        endcase
      end
      MODE_ADDR: begin
        case (scan_pos)
          2'd0: emit = 1'b0;
          2'd1: begin
            emit = (dig_hund != 4'd0);
            code = dig_hund;
          end
          2'd2: begin
            emit = (dig_hund != 4'd0) || (dig_tens != 4'd0);
            code = dig_tens;
          end
          default: begin
            emit = 1'b1;
            code = dig_ones;
          end
        endcase
      end
      MODE_OFF: emit = 1'b1;
      default:  emit = 1'b0;
    endcase
    if (display_mode == MODE_OFF) begin
      frame_next = OFF_FRAME;
    end else begin
      frame_next = {digit_select(scan_pos), glyph(code) | {7'd0, point}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= MODE_OFF;
      dig_hund     <= 4'd0;
      dig_tens     <= 4'd0;
      dig_ones     <= 4'd0;
      scan_pos     <= 2'd0;
    end else if (in_beat) begin
      if (s_axis_tuser == OP_LOAD) begin
        display_mode <= in_mode;
        dig_hund     <= hund_next;
        dig_tens     <= tens_next;
        dig_ones     <= ones_next;
      end else begin
        scan_pos <= scan_pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      bit_pos <= 4'd0;
    end else if (in_beat && s_axis_tuser == OP_TICK && emit) begin
      active  <= 1'b1;
      bit_pos <= 4'd15;
    end else if (last_beat) begin
      active <= 1'b0;
    end else if (out_beat) begin
      bit_pos <= bit_pos - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && s_axis_tuser == OP_TICK && emit) begin
      frame <= frame_next;
    end else if (out_beat) begin
      frame <= {frame[14:0], 1'b0};
    end
  end

  assign m_axis_tvalid = active;
  assign m_axis_tdata  = {3'b000, bit_pos, frame[15]};
  assign m_axis_tlast  = (bit_pos == 4'd0);

  // a frame always starts at its top bit
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> (bit_pos == 4'd15))
    else $error("frame did not start at bit 15");

  // mid-frame beats step down by one with no gap
  a_bit_step: assert property (@(posedge clk) disable iff (rst)
    (out_beat && bit_pos != 4'd0) |=>
      (m_axis_tvalid && bit_pos == $past(bit_pos) - 4'd1))
    else $error("frame bit sequence broken");

  // every tick advances the scan position, emitting or not
  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_axis_tuser == OP_TICK) |=> (scan_pos == $past(scan_pos) + 2'd1))
    else $error("scan position did not advance");

  // off mode always yields the blank frame
  a_off_frame: assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_axis_tuser == OP_TICK && display_mode == MODE_OFF) |=>
      (m_axis_tvalid && frame == OFF_FRAME && bit_pos == 4'd15))
    else $error("off mode frame wrong");

endmodule

/* tb/tb_seven_segment_scan_shift_driver_unit.sv */
// Self-checking testbench for the seven-segment scan shift driver unit.
// Predicts every serial frame bit from loads and scan ticks and checks the output stream.
// Depends on sssd_pkg and seven_segment_scan_shift_driver_unit.
module tb_seven_segment_scan_shift_driver_unit;
  import sssd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic       serial_bit;
    logic [3:0] bit_position;
    logic       latch_last;
  } frame_bit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [1:0] mode, [11:2] value, [15:12] zero
  logic        s_axis_tuser = 1'b0; // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [0] serial_bit, [4:1] bit_position, [7:5] zero
  logic        m_axis_tlast;

  // Segment bytes, A in bit 7 down to DP in bit 0, and active-low digit selects.
  logic [7:0] seg_rom [0:15] = '{8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
                                 8'hFE, 8'hF6, 8'hEE, 8'hFE, 8'h9C, 8'hFC, 8'h9E, 8'h8E};
  logic [7:0] select_rom [0:3] = '{8'h0E, 8'h0D, 8'h0B, 8'h07};

  // Shadow state of the driver
  logic [1:0] shown_mode = MODE_OFF;
  digit_t     shown_digits [0:2] = '{4'd0, 4'd0, 4'd0};
  logic [1:0] scan_slot = 2'd0;

  frame_bit_t pending_bits [$];
  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_style = 0;
  int stall_phase = 0;

  seven_segment_scan_shift_driver_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Scan tick: work out which frame (if any) this slot shows and queue its bits.
  task automatic predict_tick();
    logic       shows;
    logic       point;
    digit_t     code;
    frame_t     frame;
    frame_bit_t fb;
    shows = 1'b0;
    point = 1'b0;
    code = '0;
    frame = '0;
    case (shown_mode)
      MODE_TEMP: begin
        shows = 1'b1;
        if (scan_slot == 2'd0) begin
          code = shown_digits[0];
          point = 1'b1;
        end else if (scan_slot == 2'd3) begin
          code = LETTER_C_CODE;
        end else begin
          code = shown_digits[scan_slot];
        end
      end
      MODE_ADDR: begin
        // leading zeros blank; first slot never lit
        case (scan_slot)
          2'd1: begin
            shows = (shown_digits[0] != 0);
            code = shown_digits[0];
          end
          2'd2: begin
            shows = (shown_digits[0] != 0) || (shown_digits[1] != 0);
            code = shown_digits[1];
          end
          2'd3: begin
            shows = 1'b1;
            code = shown_digits[2];
          end
          default: shows = 1'b0;
        endcase
      end
      MODE_OFF: shows = 1'b1;
      default: shows = 1'b0;
    endcase
    if (shows) begin
      if (shown_mode == MODE_OFF) frame = OFF_FRAME;
      else frame = {select_rom[scan_slot], seg_rom[code] | {7'b0, point}};
      for (int idx = 15; idx >= 0; idx--) begin
        fb.serial_bit = frame[idx];
        fb.bit_position = idx[3:0];
        fb.latch_last = (idx == 0);
        pending_bits.push_back(fb);
      end
    end
    scan_slot = scan_slot + 2'd1;
  endtask

  // One beat into the driver; called right after a rising edge.
  task automatic send_beat(input logic op, input logic [1:0] mode, input logic [9:0] value);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, value, mode};
    s_axis_tuser <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op == OP_LOAD) begin
      shown_mode = mode;
      shown_digits[0] = digit_t'(value / 100);
      shown_digits[1] = digit_t'((value / 10) % 10);
      shown_digits[2] = digit_t'(value % 10);
    end else begin
      predict_tick();
    end
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 5);
    end else begin
      burst_left--;
    end
  endtask

  task automatic load(input logic [1:0] mode, input logic [9:0] value);
    send_beat(OP_LOAD, mode, value);
  endtask

  task automatic ticks(input int count);
    repeat (count) send_beat(OP_TICK, 2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)));
  endtask

  // Reset state is display off
  task automatic test_reset_off();
    ticks(1);
  endtask

  // Hundreds with point, tens, ones and the letter C
  task automatic test_temperature();
    load(MODE_TEMP, 10'd987);
    ticks(4);
  endtask

  // Leading-zero blanking and the skipped first digit
  task automatic test_address();
    load(MODE_ADDR, 10'd7);
    ticks(4);
    load(MODE_ADDR, 10'd42);
    ticks(2);
    load(MODE_ADDR, 10'd300);
    ticks(3);
  endtask

  // Off frame and the unused mode, which stays silent
  task automatic test_off_and_unused();
    load(MODE_OFF, 10'd0);
    ticks(1);
    load(MODE_UNUSED, 10'd1023);
    ticks(1);
  endtask

  // Values above 999 give a hundreds digit of ten
  task automatic test_overrange();
    load(MODE_TEMP, 10'd1023);
    ticks(4);
  endtask

  task automatic test_random(input int count);
    logic [1:0] mode;
    logic [9:0] value;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 6) begin
        ticks(1);
      end else begin
        mode = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
        value = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(1000, 1023))
                                             : 10'($urandom_range(0, 999));
        load(mode, value);
      end
    end
  endtask

  // Receiver stall pattern, switching to a randomly chosen style when its phase counter runs out
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(16, 96);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_style)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= (cycle_count % 3 == 0);
      default: m_axis_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    frame_bit_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_bits.size() == 0) begin
        report_mismatch($sformatf("unexpected beat data=%h last=%b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = pending_bits.pop_front();
        if (m_axis_tdata[0] !== want.serial_bit)
          report_mismatch($sformatf("serial_bit %b, expected %b at position %0d",
                                    m_axis_tdata[0], want.serial_bit, want.bit_position));
        if (m_axis_tdata[4:1] !== want.bit_position)
          report_mismatch($sformatf("bit_position %0d, expected %0d",
                                    m_axis_tdata[4:1], want.bit_position));
        if (m_axis_tlast !== want.latch_last)
          report_mismatch($sformatf("latch_last %b, expected %b at position %0d",
                                    m_axis_tlast, want.latch_last, want.bit_position));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_seven_segment_scan_shift_driver_unit: errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_off();
    test_temperature();
    test_address();
    test_off_and_unused();
    test_overrange();
    test_random(93);
    s_axis_tvalid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_seven_segment_scan_shift_driver_unit: clean");
    end else begin
      $display("tb_seven_segment_scan_shift_driver_unit: errors");
    end
    $finish;
  end

endmodule
